[rtl/tog_pkg.sv]
// tog_pkg: types, register indexes and reset constants of the tdoa outlier gate
// used by tog_front and tdoa_outlier_gate_integrator_unit
`default_nettype none

package tog_pkg;

	localparam int unsigned CfgIndexW = 8;
	localparam int unsigned LevelW    = 16;
	localparam int unsigned TimeW     = 32;

	localparam logic [LevelW-1:0] IntegratorMaxRst = 16'd300;
	localparam logic [LevelW-1:0] MaxStepRst       = 16'd30;
	localparam logic [LevelW-1:0] OpenLevelRst     = 16'd30;
	localparam logic [LevelW-1:0] CloseLevelRst    = 16'd270;

	typedef enum logic [CfgIndexW-1:0] {
		REG_INTEGRATOR_MAX = 8'd0,
		REG_MAX_STEP       = 8'd1,
		REG_OPEN_LEVEL     = 8'd2,
		REG_CLOSE_LEVEL    = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [23:0] meas_error;
		logic [22:0]        std_dev;
		logic signed [23:0] distance_diff;
		logic signed [23:0] anchor_a_x;
		logic signed [23:0] anchor_a_y;
		logic signed [23:0] anchor_a_z;
		logic signed [23:0] anchor_b_x;
		logic signed [23:0] anchor_b_y;
		logic signed [23:0] anchor_b_z;
	} in_t;

	typedef struct packed {
		logic              sample_good;
		logic              gate_open;
		logic [LevelW-1:0] integrator_level;
	} out_t;

	// per-sample verdicts from the front pipeline
	typedef struct packed {
		logic             valid;
		logic             plausible;
		logic             err_small;
		logic             err_pass;
		logic [TimeW-1:0] now_ms;
	} front_t;

endpackage

`default_nettype wire

[rtl/tog_front.sv]
// tog_front: four-stage pipeline for the geometric plausibility check and the error tests
// depends on tog_pkg
`default_nettype none

module tog_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tog_pkg::in_t  in_data,
	output tog_pkg::front_t    res,
	input  wire logic          res_ready
);
	import tog_pkg::*;

	function automatic logic [24:0] abs25(input logic signed [24:0] d);
		return d[24] ? 25'(-d) : 25'(d);
	endfunction

	function automatic logic [24:0] adiff(input logic signed [23:0] a,
		input logic signed [23:0] b);
		logic signed [24:0] d;
		d = 25'(a) - 25'(b);
		return abs25(d);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	in_t d_s1;

	logic [24:0] adx_s2, ady_s2, adz_s2;
	logic [23:0] dd_abs_s2;
	logic        small_s2, pass_s2;
	logic [31:0] now_s2;

	logic [49:0] sqx_s3, sqy_s3, sqz_s3;
	logic [47:0] dd_sq_s3;
	logic        small_s3, pass_s3;
	logic [31:0] now_s3;

	logic        plaus_s4, small_s4, pass_s4;
	logic [31:0] now_s4;

	logic [23:0] abs_err;
	logic [24:0] dd_abs_w;
	logic [25:0] sd5;
	logic [51:0] anchor_sq;

	assign rdy_s4   = !v_s4 || res_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			d_s1 <= in_data;
		end
	end

	// stage 2: magnitudes and error tests
	always_comb begin
		abs_err  = 24'(abs25(25'(d_s1.meas_error)));
		dd_abs_w = abs25(25'(d_s1.distance_diff));
		sd5      = {1'b0, d_s1.std_dev, 2'b00} + 26'(d_s1.std_dev);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			adx_s2    <= adiff(d_s1.anchor_a_x, d_s1.anchor_b_x);
			ady_s2    <= adiff(d_s1.anchor_a_y, d_s1.anchor_b_y);
			adz_s2    <= adiff(d_s1.anchor_a_z, d_s1.anchor_b_z);
			dd_abs_s2 <= dd_abs_w[23:0];
			small_s2  <= abs_err < {d_s1.std_dev, 1'b0};
			pass_s2   <= {1'b0, abs_err, 1'b0} < sd5;
			now_s2    <= d_s1.now_ms;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			sqx_s3   <= 50'(adx_s2) * 50'(adx_s2);
			sqy_s3   <= 50'(ady_s2) * 50'(ady_s2);
			sqz_s3   <= 50'(adz_s2) * 50'(adz_s2);
			dd_sq_s3 <= 48'(dd_abs_s2) * 48'(dd_abs_s2);
			small_s3 <= small_s2;
			pass_s3  <= pass_s2;
			now_s3   <= now_s2;
		end
	end

	// stage 4: anchor distance sum and compare
	assign anchor_sq = 52'(sqx_s3) + 52'(sqy_s3) + 52'(sqz_s3);

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			plaus_s4 <= 52'(dd_sq_s3) < anchor_sq;
			small_s4 <= small_s3;
			pass_s4  <= pass_s3;
			now_s4   <= now_s3;
		end
	end

	always_comb begin
		res.valid     = v_s4;
		res.plausible = plaus_s4;
		res.err_small = small_s4;
		res.err_pass  = pass_s4;
		res.now_ms    = now_s4;
	end

endmodule

`default_nettype wire

[rtl/tdoa_outlier_gate_integrator_unit.sv]
// tdoa_outlier_gate_integrator_unit: top level, config registers, integrator state, result register
// depends on tog_pkg and tog_front
//
// usage
//   in channel: one ranging sample per transfer (in_valid / in_ready / in_data)
//   out channel: one verdict per sample (out_valid / out_ready / out_data), in order
//   cfg channel: register writes by index, always ready; unknown indexes are dropped;
//     write only while no sample is in flight
//   latency: a sample accepted at one clock edge shows its result 4 edges later
//     (input register loads at the accepting edge, then magnitude stage, multiplier
//     stage, sum and compare stage, then the state update into the result register)
//   throughput: one sample per cycle; the integrator, gate flag and last timestamp
//     are read and written only in the final stage, so no sample waits on another
//   stall: each stage holds when the one after it is full, so the pipeline keeps
//     filling while a result waits; in_ready drops once all stages are occupied
//   reset: arst_n clears the pipeline, loads register defaults (300, 30, 30, 270),
//     integrator to 0, gate open, last timestamp 0
`default_nettype none

module tdoa_outlier_gate_integrator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire tog_pkg::in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output tog_pkg::out_t                          out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tog_pkg::CfgIndexW-1:0]     cfg_index,
	input  wire logic [tog_pkg::LevelW-1:0]        cfg_data
);
	import tog_pkg::*;

	front_t f;
	logic   f_ready;
	logic   take;

	logic [LevelW-1:0] imax_q, step_q, open_lvl_q, close_lvl_q;
	logic [LevelW-1:0] integ_q;
	logic              open_q;
	logic [TimeW-1:0]  last_q;
	logic              out_valid_q;
	out_t              out_q;

	logic [TimeW-1:0]  dt_full;
	logic [LevelW-1:0] dt;
	logic [LevelW:0]   rise_sum;
	logic [LevelW-1:0] integ_n;
	logic              open_n;
	logic              good_n;

	tog_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res       (f),
		.res_ready (f_ready)
	);

	assign f_ready   = !out_valid_q || out_ready;
	assign take      = f.valid && f_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imax_q      <= IntegratorMaxRst;
			step_q      <= MaxStepRst;
			open_lvl_q  <= OpenLevelRst;
			close_lvl_q <= CloseLevelRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INTEGRATOR_MAX: imax_q      <= cfg_data;
				REG_MAX_STEP:       step_q      <= cfg_data;
				REG_OPEN_LEVEL:     open_lvl_q  <= cfg_data;
				REG_CLOSE_LEVEL:    close_lvl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		dt_full  = f.now_ms - last_q;
		dt       = (dt_full > TimeW'(step_q)) ? step_q : dt_full[LevelW-1:0];
		rise_sum = {1'b0, integ_q} + {1'b0, dt};
		if (f.err_small) begin
			integ_n = (rise_sum > {1'b0, imax_q}) ? imax_q : rise_sum[LevelW-1:0];
		end else begin
			integ_n = (integ_q > dt) ? integ_q - dt : '0;
		end
		if (open_q) begin
			good_n = 1'b1;
			open_n = !(integ_n > close_lvl_q);
		end else begin
			good_n = f.err_pass;
			open_n = integ_n < open_lvl_q;
		end
		if (!f.plausible) begin
			integ_n = integ_q;
			open_n  = open_q;
			good_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			open_q      <= 1'b1;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (f_ready) out_valid_q <= f.valid;
			if (take) begin
				integ_q <= integ_n;
				open_q  <= open_n;
				if (f.plausible) last_q <= f.now_ms;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.sample_good      <= good_n;
			out_q.gate_open        <= open_n;
			out_q.integrator_level <= integ_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && !f.plausible |=> $stable(integ_q) && $stable(open_q) && $stable(last_q))
		else $error("rejected sample changed gate state");

	a_close_level: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(open_q) |-> integ_q > close_lvl_q)
		else $error("gate closed at or below close level");

	a_open_level: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(open_q) |-> integ_q < open_lvl_q)
		else $error("gate reopened at or above open level");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_q.integrator_level == integ_q && out_q.gate_open == open_q)
		else $error("result register out of step with state");

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for tdoa_outlier_gate_integrator_unit: directed and random ranging samples with
// register writes between phases, checked against an in-file model of the gate and integrator
// depends on tog_pkg and the unit under test
`timescale 1ns / 1ps

module testbench;
	import tog_pkg::*;

	localparam int PIPE_LATENCY = 5;
	localparam int HOLD_CYCLES  = 300;
	localparam int STUCK_LIMIT  = 5000;
	localparam logic [CfgIndexW-1:0] REG_NONE_LOW  = 8'd4;
	localparam logic [CfgIndexW-1:0] REG_NONE_HIGH = 8'hFF;
	localparam longint ERR_MAX = 8388607;

	typedef struct packed {
		logic [CfgIndexW-1:0] index;
		logic [LevelW-1:0]    value;
	} reg_write_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [LevelW-1:0]    cfg_data = '0;

	in_t        sample_q[$];
	reg_write_t reg_write_q[$];
	out_t       verdict_q[$];

	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic pressure_go = 1'b0;
	logic receiver_hold = 1'b0;
	int   mismatch_count = 0;
	int   stuck_cycles = 0;
	logic [31:0] stim_ms = 32'd11000;

	// gate model state and registers
	logic [LevelW-1:0] lim_integrator = IntegratorMaxRst;
	logic [LevelW-1:0] lim_step = MaxStepRst;
	logic [LevelW-1:0] lvl_open = OpenLevelRst;
	logic [LevelW-1:0] lvl_close = CloseLevelRst;
	int unsigned       integ = 0;
	logic              gate_is_open = 1'b1;
	logic [31:0]       last_ms = '0;

	tdoa_outlier_gate_integrator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint to_long(logic signed [23:0] v);
		return longint'(v);
	endfunction

	function automatic longint absval(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic out_t predict_verdict(in_t s);
		longint      err_mag, sd, dd, dx, dy, dz;
		logic [31:0] step;
		int unsigned sum;
		out_t        v;
		err_mag = absval(to_long(s.meas_error));
		sd = longint'(s.std_dev);
		dd = to_long(s.distance_diff);
		dx = to_long(s.anchor_a_x) - to_long(s.anchor_b_x);
		dy = to_long(s.anchor_a_y) - to_long(s.anchor_b_y);
		dz = to_long(s.anchor_a_z) - to_long(s.anchor_b_z);
		v.sample_good = 1'b0;
		if (dd * dd < dx * dx + dy * dy + dz * dz) begin
			step = s.now_ms - last_ms;
			if (step > 32'(lim_step)) begin
				step = 32'(lim_step);
			end
			if (err_mag < 2 * sd) begin
				sum = integ + step;
				integ = (sum > 32'(lim_integrator)) ? 32'(lim_integrator) : sum;
			end else begin
				integ = (integ > step) ? integ - step : 32'd0;
			end
			if (gate_is_open) begin
				v.sample_good = 1'b1;
				if (integ > 32'(lvl_close)) begin
					gate_is_open = 1'b0;
				end
			end else begin
				v.sample_good = (2 * err_mag < 5 * sd);
				if (integ < 32'(lvl_open)) begin
					gate_is_open = 1'b1;
				end
			end
			last_ms = s.now_ms;
		end
		v.gate_open = gate_is_open;
		v.integrator_level = integ[15:0];
		return v;
	endfunction

	// driver for the sample and register channels, predicts on each accepted sample
	always @(posedge clk or negedge arst_n) begin : driver
		reg_write_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				verdict_q.push_back(predict_verdict(in_data));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INTEGRATOR_MAX: lim_integrator = cfg_data;
					REG_MAX_STEP:       lim_step = cfg_data;
					REG_OPEN_LEVEL:     lvl_open = cfg_data;
					REG_CLOSE_LEVEL:    lvl_close = cfg_data;
					default: ;
				endcase
			end
			if (!in_valid || in_ready) begin
				if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= sample_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_write_q.size() > 0) begin
					w = reg_write_q.pop_front();
					cfg_index <= w.index;
					cfg_data <= w.value;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("%0t: verdict with no sample pending: good=%0b open=%0b level=%0d",
							$time, out_data.sample_good, out_data.gate_open,
							out_data.integrator_level);
					end
					mismatch_count++;
				end else begin
					want = verdict_q.pop_front();
					if (out_data.sample_good !== want.sample_good ||
							out_data.gate_open !== want.gate_open ||
							out_data.integrator_level !== want.integrator_level) begin
						if (mismatch_count < 10) begin
							$display("%0t: expected good=%0b open=%0b level=%0d, got %0b %0b %0d",
								$time, want.sample_good, want.gate_open, want.integrator_level,
								out_data.sample_good, out_data.gate_open,
								out_data.integrator_level);
						end
						mismatch_count++;
					end
				end
			end
			out_ready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off so the pipeline fills and stalls its input
	initial begin : hold_off
		wait (pressure_go);
		@(posedge clk);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (sample_q.size() != 0 || in_valid || verdict_q.size() != 0 ||
			reg_write_q.size() != 0 || cfg_valid);
		repeat (PIPE_LATENCY) @(negedge clk);
	endtask

	task automatic set_reg(logic [CfgIndexW-1:0] index, logic [LevelW-1:0] value);
		wait_drained();
		reg_write_q.push_back('{index, value});
		wait_drained();
	endtask

	task automatic configure(int unsigned lim, int unsigned step, int unsigned open_lvl,
			int unsigned close_lvl);
		set_reg(REG_INTEGRATOR_MAX, LevelW'(lim));
		set_reg(REG_MAX_STEP, LevelW'(step));
		set_reg(REG_OPEN_LEVEL, LevelW'(open_lvl));
		set_reg(REG_CLOSE_LEVEL, LevelW'(close_lvl));
	endtask

	task automatic queue_sample(logic [31:0] now, int err, int sd, int dd,
			int ax, int ay, int az, int bx, int by, int bz);
		in_t s;
		s.now_ms = now;
		s.meas_error = 24'(err);
		s.std_dev = 23'(sd);
		s.distance_diff = 24'(dd);
		s.anchor_a_x = 24'(ax);
		s.anchor_a_y = 24'(ay);
		s.anchor_a_z = 24'(az);
		s.anchor_b_x = 24'(bx);
		s.anchor_b_y = 24'(by);
		s.anchor_b_z = 24'(bz);
		sample_q.push_back(s);
	endtask

	// err_mode 0: inside 2 sigma, 1: outside, 2: around both thresholds
	function automatic in_t plausible_sample(int err_mode);
		in_t    s;
		longint m, mag, sd;
		if ($urandom_range(0, 15) == 0) begin
			stim_ms += $urandom;
		end else begin
			stim_ms += $urandom_range(0, 40);
		end
		s.now_ms = stim_ms;
		if ($urandom_range(0, 7) == 0) begin
			s.anchor_a_x = 24'($urandom);
			s.anchor_a_y = 24'($urandom);
			s.anchor_a_z = 24'($urandom);
			s.anchor_b_x = 24'($urandom);
			s.anchor_b_y = 24'($urandom);
			s.anchor_b_z = 24'($urandom);
		end else begin
			s.anchor_a_x = 24'($urandom_range(0, 1 << 23) - (1 << 22));
			s.anchor_a_y = 24'($urandom_range(0, 1 << 23) - (1 << 22));
			s.anchor_a_z = 24'($urandom_range(0, 1 << 23) - (1 << 22));
			s.anchor_b_x = s.anchor_a_x + 24'($urandom_range(0, 1 << 21) - (1 << 20));
			s.anchor_b_y = s.anchor_a_y + 24'($urandom_range(0, 1 << 21) - (1 << 20));
			s.anchor_b_z = s.anchor_a_z + 24'($urandom_range(0, 1 << 21) - (1 << 20));
		end
		m = absval(to_long(s.anchor_a_x) - to_long(s.anchor_b_x));
		mag = absval(to_long(s.anchor_a_y) - to_long(s.anchor_b_y));
		if (mag > m) m = mag;
		mag = absval(to_long(s.anchor_a_z) - to_long(s.anchor_b_z));
		if (mag > m) m = mag;
		if (m == 0) begin
			mag = 0;
		end else if ($urandom_range(0, 3) == 0) begin
			mag = m - 1;
		end else begin
			mag = longint'($urandom_range(0, 32'(m - 1)));
		end
		if (mag > ERR_MAX) mag = ERR_MAX;
		s.distance_diff = 24'($urandom_range(0, 1) ? -mag : mag);
		if ($urandom_range(0, 9) == 0) begin
			sd = longint'($urandom_range(0, 8388607));
		end else begin
			sd = longint'($urandom_range(0, 4096));
		end
		s.std_dev = 23'(sd);
		case (err_mode)
			0: mag = (sd == 0) ? 0 : longint'($urandom_range(0, 32'(2 * sd - 1)));
			1: mag = 2 * sd + longint'($urandom_range(0, 32'(3 * sd + 2)));
			default: begin
				case ($urandom_range(0, 4))
					0: mag = 2 * sd - 1;
					1: mag = 2 * sd;
					2: mag = (5 * sd - 1) / 2;
					3: mag = (5 * sd + 1) / 2;
					default: mag = longint'($urandom_range(0, 32'(3 * sd)));
				endcase
			end
		endcase
		if (mag < 0) mag = 0;
		if (mag > ERR_MAX) mag = ERR_MAX;
		s.meas_error = 24'($urandom_range(0, 1) ? -mag : mag);
		return s;
	endfunction

	// distance difference at or beyond the anchor separation
	function automatic in_t impossible_sample();
		in_t    s;
		longint m, mag;
		s = plausible_sample($urandom_range(0, 2));
		s.anchor_b_y = s.anchor_a_y;
		s.anchor_b_z = s.anchor_a_z;
		m = absval(to_long(s.anchor_a_x) - to_long(s.anchor_b_x));
		if (m > ERR_MAX) begin
			s.anchor_b_x = s.anchor_a_x;
			m = 0;
		end
		mag = $urandom_range(0, 1) ? m : m + longint'($urandom_range(1, 1000));
		if (mag > ERR_MAX) mag = m;
		s.distance_diff = 24'($urandom_range(0, 1) ? -mag : mag);
		return s;
	endfunction

	function automatic in_t noise_sample();
		in_t s;
		s.now_ms = $urandom;
		s.meas_error = 24'($urandom);
		s.std_dev = 23'($urandom);
		s.distance_diff = 24'($urandom);
		s.anchor_a_x = 24'($urandom);
		s.anchor_a_y = 24'($urandom);
		s.anchor_a_z = 24'($urandom);
		s.anchor_b_x = 24'($urandom);
		s.anchor_b_y = 24'($urandom);
		s.anchor_b_z = 24'($urandom);
		return s;
	endfunction

	task automatic queue_traffic(int count);
		int left, kind, run, err_mode;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				sample_q.push_back(noise_sample());
				left--;
			end else if (kind == 1) begin
				sample_q.push_back(impossible_sample());
				left--;
			end else begin
				run = $urandom_range(3, 30);
				err_mode = $urandom_range(0, 2);
				for (int i = 0; i < run && left > 0; i++) begin
					sample_q.push_back(plausible_sample(err_mode));
					left--;
				end
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: extremes, impossible geometry, threshold ties, time wrap
		queue_sample(32'hFFFF_FFFF, -8388608, 8388607, -8388608, 8388607, 0, 0, -8388608, 0, 0);
		queue_sample(32'd5, 8388607, 0, 8388607, -8388608, -8388608, -8388608,
			8388607, 8388607, 8388607);
		queue_sample(32'd100, 0, 10, 0, 1000, 2000, 3000, 1000, 2000, 3000);
		queue_sample(32'd120, 3, 10, 500, 0, 0, 0, 300, 400, 0);
		queue_sample(32'd140, 3, 10, -499, 0, 0, 0, 300, 400, 0);
		queue_sample(32'd150, 200, 100, 0, -5, 0, 0, 5, 0, 0);
		queue_sample(32'd160, 0, 0, 1, 0, 0, 0, 0, 0, 7);
		queue_sample(32'd20, -4096, 4096, 1, 0, 0, 0, 0, 9, 0);

		// close the gate, test the closed pass window, reopen
		configure(100, 65535, 20, 50);
		set_reg(REG_NONE_LOW, 16'hFFFF);
		set_reg(REG_NONE_HIGH, 16'h0001);
		queue_sample(32'd10000, 1, 10, 0, 0, 0, 0, 100, 0, 0);
		queue_sample(32'd10010, 250, 100, 0, 0, 0, 0, 100, 0, 0);
		queue_sample(32'd10020, -249, 100, 0, 0, 0, 0, 100, 0, 0);
		queue_sample(32'd10090, 1000, 10, 0, 0, 0, 0, 100, 0, 0);
		queue_sample(32'd10200, 0, 5, 0, 0, 0, 0, 100, 0, 0);
		// lowered limit: a fall keeps the level above it, the next rise clamps
		set_reg(REG_INTEGRATOR_MAX, 16'd40);
		queue_sample(32'd10205, 500, 10, 0, 0, 0, 0, 100, 0, 0);
		queue_sample(32'd10210, 2, 10, 0, 0, 0, 0, 100, 0, 0);
		set_reg(REG_INTEGRATOR_MAX, 16'd0);
		queue_sample(32'd10300, 0, 1, 0, 0, 0, 0, 100, 0, 0);
		queue_sample(32'd10400, 0, 1, 0, 0, 0, 0, 100, 0, 0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure($urandom_range(1, 600), $urandom_range(0, 100),
					$urandom_range(0, 300), $urandom_range(0, 600));
				1: configure(65535, 65535, 0, 65535);
				2: configure($urandom_range(1, 600), $urandom_range(0, 100),
					$urandom_range(0, 300), $urandom_range(0, 600));
				3: configure(1, 65535, 0, 0);
				4: configure($urandom_range(1, 600), $urandom_range(0, 100),
					$urandom_range(0, 300), $urandom_range(0, 600));
				default: configure(65535, 0, 65535, 65535);
			endcase
			send_idle_pct = (p == 1) ? 49 : (p == 3 || p == 5) ? 34 : 0;
			stall_pct = (p == 2) ? 49 : (p == 3 || p == 5) ? 34 : 0;
			queue_traffic((p == 5) ? 80 : 200);
			if (p == 4) begin
				pressure_go = 1'b1;
			end
		end

		wait_drained();
		if (mismatch_count == 0 && verdict_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[tdoa_outlier_gate_integrator_unit.f]
rtl/tog_pkg.sv
rtl/tog_front.sv
rtl/tdoa_outlier_gate_integrator_unit.sv
verif/testbench.sv
